[sv/pcw_pkg.sv]
// Package for the power-cycling watchdog: request and status codes,
// state, configuration and result structs, and the channel mask helper.
// No dependencies.
package pcw_pkg;

   localparam int NUM_CHANNELS = 6;

   localparam int MODE_W = 3;
   localparam int CHAN_W = 3;
   localparam int STAT_W = 2;
   localparam int WDOG_W = 16;
   localparam int REL_W  = 8;
   localparam int TICK_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [WDOG_W-1:0] WDOG_SECONDS_RST = 16'd660;
   localparam logic [REL_W-1:0]  REL_SECONDS_RST  = 8'd10;
   localparam logic [TICK_W-1:0] TICKS_PER_SEC_RST = 8'd40;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK    = 3'd0,
      MODE_WDOG_ON = 3'd1,
      MODE_WDOG_OFF = 3'd2,
      MODE_PING    = 3'd3,
      MODE_CHAN_SET = 3'd4
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK          = 2'd0,
      ST_BAD_WDOG_CH = 2'd1,
      ST_BAD_CHAN    = 2'd2,
      ST_GUARDED     = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WDOG_SECONDS  = 2'd0,
      CSR_REL_SECONDS   = 2'd1,
      CSR_TICKS_PER_SEC = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [WDOG_W-1:0] wdog_seconds;
      logic [REL_W-1:0]  rel_seconds;
      logic [TICK_W-1:0] ticks_per_sec;
   } cfg_type;

   typedef struct packed {
      logic [NUM_CHANNELS-1:0] chan_bits;
      logic [CHAN_W-1:0]       guard;
      logic [WDOG_W-1:0]       wdog_cnt;
      logic [REL_W-1:0]        rel_cnt;
      logic [CHAN_W-1:0]       rel_chan;
      logic [TICK_W-1:0]       tick_cnt;
   } state_type;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic                    cut_event;
      logic                    restore_event;
      logic [NUM_CHANNELS-1:0] outputs_now;
      logic [CHAN_W-1:0]       guard_now;
      logic [WDOG_W-1:0]       seconds_left;
   } result_type;

   function automatic logic chan_ok(input logic [CHAN_W-1:0] ch);
      return (ch != '0) && ({1'b0, ch} <= (CHAN_W+1)'(NUM_CHANNELS));
   endfunction

   // One-hot mask of a channel, zero when out of range.
   function automatic logic [NUM_CHANNELS-1:0] chan_mask(input logic [CHAN_W-1:0] ch);
      logic [NUM_CHANNELS-1:0] m;
      m = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (ch == CHAN_W'(i + 1)) m[i] = 1'b1;
      end
      return m;
   endfunction

endpackage

[sv/pcw_step.sv]
// Next-state and result logic for one request of the power-cycling watchdog.
// Purely combinational; depends on pcw_pkg.
module pcw_step (
   input  pcw_pkg::state_type            state_cur,
   input  pcw_pkg::cfg_type              cfg,
   input  logic [pcw_pkg::MODE_W-1:0]    mode,
   input  logic [pcw_pkg::CHAN_W-1:0]    channel,
   input  logic                          level,
   output pcw_pkg::state_type            state_nxt,
   output pcw_pkg::result_type           result
);

   logic [pcw_pkg::TICK_W-1:0] tick_inc;
   logic                       sec_fire;
   logic [pcw_pkg::WDOG_W-1:0] wdog_dec;
   logic                       cut;
   logic                       restore;
   logic [pcw_pkg::REL_W-1:0]  rel_loaded;
   logic [pcw_pkg::REL_W-1:0]  rel_dec;
   logic [pcw_pkg::NUM_CHANNELS-1:0] bits_cut;
   logic [pcw_pkg::CHAN_W-1:0] rel_chan_cut;
   logic [pcw_pkg::STAT_W-1:0] status;

   assign tick_inc = state_cur.tick_cnt + 1'b1;
   assign sec_fire = (tick_inc >= cfg.ticks_per_sec);
   assign wdog_dec = state_cur.wdog_cnt - 1'b1;

   always_comb begin
      state_nxt = state_cur;
      status    = pcw_pkg::ST_OK;
      cut       = 1'b0;
      restore   = 1'b0;
      rel_loaded   = state_cur.rel_cnt;
      rel_chan_cut = state_cur.rel_chan;
      bits_cut     = state_cur.chan_bits;
      rel_dec      = '0;

      case (mode)
         pcw_pkg::MODE_TICK: begin
            state_nxt.tick_cnt = tick_inc;
            if (sec_fire) begin
               state_nxt.tick_cnt = '0;
               if (state_cur.guard != '0 && state_cur.wdog_cnt != '0) begin
                  state_nxt.wdog_cnt = wdog_dec;
                  if (wdog_dec == '0) begin
                     cut          = 1'b1;
                     rel_chan_cut = state_cur.guard;
                     bits_cut     = state_cur.chan_bits & ~pcw_pkg::chan_mask(state_cur.guard);
                     rel_loaded   = (cfg.rel_seconds != '0) ? cfg.rel_seconds
                                                            : pcw_pkg::REL_W'(1);
                  end
               end
               state_nxt.rel_chan  = rel_chan_cut;
               state_nxt.chan_bits = bits_cut;
               state_nxt.rel_cnt   = rel_loaded;
               if (rel_loaded != '0) begin
                  rel_dec = rel_loaded - 1'b1;
                  state_nxt.rel_cnt = rel_dec;
                  if (rel_dec == '0 && pcw_pkg::chan_ok(rel_chan_cut)) begin
                     restore = 1'b1;
                     state_nxt.chan_bits = bits_cut | pcw_pkg::chan_mask(rel_chan_cut);
                  end
               end
            end
         end
         pcw_pkg::MODE_WDOG_ON: begin
            if (pcw_pkg::chan_ok(channel)) begin
               state_nxt.guard    = channel;
               state_nxt.wdog_cnt = cfg.wdog_seconds;
            end else begin
               status = pcw_pkg::ST_BAD_WDOG_CH;
            end
         end
         pcw_pkg::MODE_WDOG_OFF: begin
            state_nxt.guard    = '0;
            state_nxt.wdog_cnt = '0;
         end
         pcw_pkg::MODE_PING: begin
            state_nxt.wdog_cnt = cfg.wdog_seconds;
         end
         pcw_pkg::MODE_CHAN_SET: begin
            if (!pcw_pkg::chan_ok(channel)) begin
               status = pcw_pkg::ST_BAD_CHAN;
            end else if (channel == state_cur.guard) begin
               status = pcw_pkg::ST_GUARDED;
            end else if (level) begin
               state_nxt.chan_bits = state_cur.chan_bits | pcw_pkg::chan_mask(channel);
            end else begin
               state_nxt.chan_bits = state_cur.chan_bits & ~pcw_pkg::chan_mask(channel);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.status        = status;
      result.cut_event     = cut;
      result.restore_event = restore;
      result.outputs_now   = state_nxt.chan_bits;
      result.guard_now     = state_nxt.guard;
      result.seconds_left  = (state_nxt.guard != '0) ? state_nxt.wdog_cnt : '0;
   end

endmodule

[sv/power_cycle_watchdog.sv]
// Power-cycling watchdog over six switched channels: state, configuration
// registers, result register and handshakes. Depends on pcw_pkg, pcw_step.
//
// One request is taken per clock cycle and its response appears in the
// result register on the next cycle. Each request updates the channel,
// watchdog, release and tick-prescaler state in a single pass, so the
// input stalls only while a response is held in the result register by a
// stall on the response side. Configuration writes are taken every cycle.
module power_cycle_watchdog (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [pcw_pkg::MODE_W-1:0]            req_mode,
   input  logic [pcw_pkg::CHAN_W-1:0]            req_channel,
   input  logic                                  req_level,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [pcw_pkg::STAT_W-1:0]            rsp_status,
   output logic                                  rsp_cut_event,
   output logic                                  rsp_restore_event,
   output logic [pcw_pkg::NUM_CHANNELS-1:0]      rsp_outputs_now,
   output logic [pcw_pkg::CHAN_W-1:0]            rsp_guard_now,
   output logic [pcw_pkg::WDOG_W-1:0]            rsp_seconds_left,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pcw_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pcw_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   pcw_pkg::cfg_type    cfg_ff;
   pcw_pkg::state_type  state_ff;
   pcw_pkg::state_type  state_in;
   pcw_pkg::result_type result_ff;
   pcw_pkg::result_type result_in;
   logic                rsp_valid_ff;
   logic                req_accept;
   logic                rsp_accept;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign csr_ready  = 1'b1;

   pcw_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .mode      (req_mode),
      .channel   (req_channel),
      .level     (req_level),
      .state_nxt (state_in),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wdog_seconds  <= pcw_pkg::WDOG_SECONDS_RST;
         cfg_ff.rel_seconds   <= pcw_pkg::REL_SECONDS_RST;
         cfg_ff.ticks_per_sec <= pcw_pkg::TICKS_PER_SEC_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pcw_pkg::CSR_WDOG_SECONDS: cfg_ff.wdog_seconds <= csr_wdata;
            pcw_pkg::CSR_REL_SECONDS:  cfg_ff.rel_seconds  <= csr_wdata[pcw_pkg::REL_W-1:0];
            pcw_pkg::CSR_TICKS_PER_SEC:
               cfg_ff.ticks_per_sec <= csr_wdata[pcw_pkg::TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.chan_bits <= '1;
         state_ff.guard     <= '0;
         state_ff.wdog_cnt  <= '0;
         state_ff.rel_cnt   <= '0;
         state_ff.rel_chan  <= '0;
         state_ff.tick_cnt  <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = result_ff.status;
   assign rsp_cut_event     = result_ff.cut_event;
   assign rsp_restore_event = result_ff.restore_event;
   assign rsp_outputs_now   = result_ff.outputs_now;
   assign rsp_guard_now     = result_ff.guard_now;
   assign rsp_seconds_left  = result_ff.seconds_left;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_guard_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.guard == '0 || pcw_pkg::chan_ok(state_ff.guard))
      else $error("guarded channel out of range");

   a_release_chan: assert property (@(posedge clock) disable iff (reset)
      state_ff.rel_cnt != '0 |-> pcw_pkg::chan_ok(state_ff.rel_chan))
      else $error("release pending on invalid channel");

   a_events_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_mode != pcw_pkg::MODE_TICK
      |=> !rsp_cut_event && !rsp_restore_event)
      else $error("cut or restore outside a tick");

   a_cut_clears_bit: assert property (@(posedge clock) disable iff (reset)
      req_accept && result_in.cut_event && !result_in.restore_event
      |=> (state_ff.chan_bits & pcw_pkg::chan_mask(state_ff.rel_chan)) == '0)
      else $error("cut left the channel on");

endmodule

[dv/power_cycle_watchdog_tb.sv]
// Testbench for power_cycle_watchdog: directed, configuration and random
// requests, checked against an in-bench model of the watchdog.
// Depends on pcw_pkg and the power_cycle_watchdog RTL.
module power_cycle_watchdog_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_COUNT = 4;
   localparam int PHASE_REQUESTS = 375;
   localparam int FIELD_W = pcw_pkg::WDOG_W;
   localparam logic [pcw_pkg::MODE_W-1:0] FIRST_SPARE_MODE = 3'd5;
   localparam logic [pcw_pkg::MODE_W-1:0] LAST_SPARE_MODE = '1;
   localparam logic [pcw_pkg::CHAN_W-1:0] NO_CHANNEL = '0;
   localparam logic [pcw_pkg::CHAN_W-1:0] TOP_CHANNEL = '1;
   localparam logic [pcw_pkg::CHAN_W-1:0] LAST_CHANNEL =
      pcw_pkg::CHAN_W'(pcw_pkg::NUM_CHANNELS);
   localparam logic [pcw_pkg::CSR_INDEX_W-1:0] CSR_SPARE = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [pcw_pkg::MODE_W-1:0] req_mode = '0;
   logic [pcw_pkg::CHAN_W-1:0] req_channel = '0;
   logic req_level = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [pcw_pkg::STAT_W-1:0] rsp_status;
   logic rsp_cut_event;
   logic rsp_restore_event;
   logic [pcw_pkg::NUM_CHANNELS-1:0] rsp_outputs_now;
   logic [pcw_pkg::CHAN_W-1:0] rsp_guard_now;
   logic [pcw_pkg::WDOG_W-1:0] rsp_seconds_left;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pcw_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pcw_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   pcw_pkg::cfg_type active_cfg;
   pcw_pkg::state_type switch_state;
   pcw_pkg::result_type pending_results[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit idle_enable = 1'b1;

   power_cycle_watchdog dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_channel(req_channel),
      .req_level(req_level),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_cut_event(rsp_cut_event),
      .rsp_restore_event(rsp_restore_event),
      .rsp_outputs_now(rsp_outputs_now),
      .rsp_guard_now(rsp_guard_now),
      .rsp_seconds_left(rsp_seconds_left),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int idle_cycles();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int sender_gap();
      if (!idle_enable || $urandom_range(0, 1) == 0) return 0;
      return idle_cycles();
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
      end else if (idle_enable && !rsp_stall && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = idle_cycles() - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = $urandom_range(0, 12);
      end
   end

   // one-hot bit of a channel, zero when out of range
   function automatic logic [pcw_pkg::NUM_CHANNELS-1:0] channel_bit(
         logic [pcw_pkg::CHAN_W-1:0] ch);
      if (ch == NO_CHANNEL || ch > LAST_CHANNEL) return '0;
      return pcw_pkg::NUM_CHANNELS'(1) << (ch - 1'b1);
   endfunction

   function automatic pcw_pkg::result_type next_watchdog_result(
         logic [pcw_pkg::MODE_W-1:0] m, logic [pcw_pkg::CHAN_W-1:0] ch, logic lv);
      pcw_pkg::result_type r;
      r = '0;
      r.status = pcw_pkg::ST_OK;
      case (m)
         pcw_pkg::MODE_TICK: begin
            switch_state.tick_cnt = switch_state.tick_cnt + 1'b1;
            if (switch_state.tick_cnt >= active_cfg.ticks_per_sec) begin
               switch_state.tick_cnt = '0;
               if (switch_state.guard != NO_CHANNEL && switch_state.wdog_cnt != '0) begin
                  switch_state.wdog_cnt = switch_state.wdog_cnt - 1'b1;
                  if (switch_state.wdog_cnt == '0) begin
                     r.cut_event = 1'b1;
                     switch_state.rel_chan = switch_state.guard;
                     switch_state.chan_bits &= ~channel_bit(switch_state.guard);
                     switch_state.rel_cnt = (active_cfg.rel_seconds != '0) ?
                                            active_cfg.rel_seconds : pcw_pkg::REL_W'(1);
                  end
               end
               // cut comes first, so a fresh release count drops in this second
               if (switch_state.rel_cnt != '0) begin
                  switch_state.rel_cnt = switch_state.rel_cnt - 1'b1;
                  if (switch_state.rel_cnt == '0 && channel_bit(switch_state.rel_chan) != '0) begin
                     r.restore_event = 1'b1;
                     switch_state.chan_bits |= channel_bit(switch_state.rel_chan);
                  end
               end
            end
         end
         pcw_pkg::MODE_WDOG_ON: begin
            if (channel_bit(ch) == '0) begin
               r.status = pcw_pkg::ST_BAD_WDOG_CH;
            end else begin
               switch_state.guard = ch;
               switch_state.wdog_cnt = active_cfg.wdog_seconds;
            end
         end
         pcw_pkg::MODE_WDOG_OFF: begin
            switch_state.guard = NO_CHANNEL;
            switch_state.wdog_cnt = '0;
         end
         pcw_pkg::MODE_PING: switch_state.wdog_cnt = active_cfg.wdog_seconds;
         pcw_pkg::MODE_CHAN_SET: begin
            if (channel_bit(ch) == '0) r.status = pcw_pkg::ST_BAD_CHAN;
            else if (ch == switch_state.guard) r.status = pcw_pkg::ST_GUARDED;
            else if (lv) switch_state.chan_bits |= channel_bit(ch);
            else switch_state.chan_bits &= ~channel_bit(ch);
         end
         default: ;
      endcase
      r.outputs_now = switch_state.chan_bits;
      r.guard_now = switch_state.guard;
      r.seconds_left = (switch_state.guard != NO_CHANNEL) ? switch_state.wdog_cnt : '0;
      return r;
   endfunction

   task automatic compare_field(string name, logic [FIELD_W-1:0] want,
                                logic [FIELD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      pcw_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("status", FIELD_W'(want.status), FIELD_W'(rsp_status));
            compare_field("cut_event", FIELD_W'(want.cut_event), FIELD_W'(rsp_cut_event));
            compare_field("restore_event", FIELD_W'(want.restore_event),
                          FIELD_W'(rsp_restore_event));
            compare_field("outputs_now", FIELD_W'(want.outputs_now),
                          FIELD_W'(rsp_outputs_now));
            compare_field("guard_now", FIELD_W'(want.guard_now), FIELD_W'(rsp_guard_now));
            compare_field("seconds_left", want.seconds_left, rsp_seconds_left);
         end
      end
   end

   task automatic send_request(logic [pcw_pkg::MODE_W-1:0] m,
                               logic [pcw_pkg::CHAN_W-1:0] ch, logic lv);
      int gap;
      req_valid <= 1'b1;
      req_mode <= m;
      req_channel <= ch;
      req_level <= lv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(next_watchdog_result(m, ch, lv));
      gap = sender_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [pcw_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [pcw_pkg::CSR_DATA_W-1:0] data);
      wait_for_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         pcw_pkg::CSR_WDOG_SECONDS: active_cfg.wdog_seconds = data;
         pcw_pkg::CSR_REL_SECONDS: active_cfg.rel_seconds = data[pcw_pkg::REL_W-1:0];
         pcw_pkg::CSR_TICKS_PER_SEC: active_cfg.ticks_per_sec = data[pcw_pkg::TICK_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_ticks(int count);
      for (int i = 0; i < count; i++) begin
         send_request(pcw_pkg::MODE_TICK, pcw_pkg::CHAN_W'($urandom), 1'($urandom));
      end
   endtask

   task automatic test_commands();
      send_request(pcw_pkg::MODE_TICK, TOP_CHANNEL, 1'b1);
      send_request(pcw_pkg::MODE_CHAN_SET, NO_CHANNEL, 1'b1);
      send_request(pcw_pkg::MODE_CHAN_SET, TOP_CHANNEL, 1'b0);
      send_request(pcw_pkg::MODE_CHAN_SET, 3'd1, 1'b0);
      send_request(pcw_pkg::MODE_CHAN_SET, 3'd6, 1'b0);
      send_request(pcw_pkg::MODE_CHAN_SET, 3'd1, 1'b1);
      send_request(pcw_pkg::MODE_WDOG_ON, NO_CHANNEL, 1'b0);
      send_request(pcw_pkg::MODE_WDOG_ON, TOP_CHANNEL, 1'b1);
      send_request(pcw_pkg::MODE_PING, 3'd2, 1'b0);
      send_request(pcw_pkg::MODE_WDOG_ON, 3'd6, 1'b0);
      send_request(pcw_pkg::MODE_CHAN_SET, 3'd6, 1'b0);
      send_request(pcw_pkg::MODE_CHAN_SET, TOP_CHANNEL, 1'b1);
      send_request(pcw_pkg::MODE_TICK, NO_CHANNEL, 1'b0);
      send_request(pcw_pkg::MODE_PING, NO_CHANNEL, 1'b1);
      send_request(FIRST_SPARE_MODE, 3'd3, 1'b1);
      send_request(FIRST_SPARE_MODE + 1'b1, 3'd5, 1'b0);
      send_request(LAST_SPARE_MODE, TOP_CHANNEL, 1'b1);
      send_request(pcw_pkg::MODE_WDOG_ON, 3'd1, 1'b1);
      send_request(pcw_pkg::MODE_WDOG_OFF, 3'd4, 1'b1);
      send_request(pcw_pkg::MODE_CHAN_SET, 3'd6, 1'b1);
      send_request(pcw_pkg::MODE_CHAN_SET, 3'd3, 1'b1);
   endtask

   task automatic test_config_extremes();
      // zero divider, zero release: cut and restore on one tick
      write_register(pcw_pkg::CSR_TICKS_PER_SEC, '0);
      write_register(pcw_pkg::CSR_REL_SECONDS, '0);
      write_register(pcw_pkg::CSR_WDOG_SECONDS, 16'd1);
      send_request(pcw_pkg::MODE_WDOG_ON, 3'd3, 1'b0);
      send_ticks(2);
      // release finishes on the latched channel after watchdog off
      write_register(pcw_pkg::CSR_WDOG_SECONDS, 16'd2);
      write_register(pcw_pkg::CSR_REL_SECONDS, 16'hA503);
      send_request(pcw_pkg::MODE_WDOG_ON, 3'd2, 1'b1);
      send_ticks(2);
      send_request(pcw_pkg::MODE_WDOG_OFF, NO_CHANNEL, 1'b0);
      send_request(pcw_pkg::MODE_CHAN_SET, 3'd2, 1'b0);
      send_ticks(3);
      // zero timeout never cuts
      write_register(pcw_pkg::CSR_WDOG_SECONDS, '0);
      send_request(pcw_pkg::MODE_WDOG_ON, 3'd4, 1'b1);
      send_ticks(3);
      send_request(pcw_pkg::MODE_PING, 3'd4, 1'b0);
      write_register(pcw_pkg::CSR_WDOG_SECONDS, '1);
      send_request(pcw_pkg::MODE_WDOG_ON, 3'd5, 1'b0);
      send_ticks(1);
      // widest divider, then lowered with ticks already counted
      write_register(pcw_pkg::CSR_TICKS_PER_SEC, '1);
      write_register(pcw_pkg::CSR_REL_SECONDS, '1);
      send_ticks(262);
      write_register(pcw_pkg::CSR_TICKS_PER_SEC, 16'h0003);
      send_ticks(1);
      write_register(CSR_SPARE, pcw_pkg::CSR_DATA_W'($urandom));
      write_register(pcw_pkg::CSR_WDOG_SECONDS, 16'd1);
      send_request(pcw_pkg::MODE_WDOG_ON, 3'd1, 1'b1);
      send_ticks(4);
      send_request(pcw_pkg::MODE_CHAN_SET, 3'd1, 1'b1);
      send_request(pcw_pkg::MODE_WDOG_OFF, 3'd1, 1'b0);
      send_request(pcw_pkg::MODE_CHAN_SET, 3'd1, 1'b1);
   endtask

   task automatic send_random_request();
      logic [pcw_pkg::MODE_W-1:0] m;
      logic [pcw_pkg::CHAN_W-1:0] ch;
      int pick;
      pick = $urandom_range(0, 99);
      ch = pcw_pkg::CHAN_W'($urandom);
      if (pick < 58) begin
         m = pcw_pkg::MODE_TICK;
      end else if (pick < 63) begin
         m = pcw_pkg::MODE_WDOG_ON;
         if ($urandom_range(0, 7) != 0) begin
            ch = pcw_pkg::CHAN_W'($urandom_range(1, pcw_pkg::NUM_CHANNELS));
         end
      end else if (pick < 66) begin
         m = pcw_pkg::MODE_WDOG_OFF;
      end else if (pick < 72) begin
         m = pcw_pkg::MODE_PING;
      end else if (pick < 95) begin
         m = pcw_pkg::MODE_CHAN_SET;
      end else begin
         m = pcw_pkg::MODE_W'($urandom_range(FIRST_SPARE_MODE, LAST_SPARE_MODE));
      end
      send_request(m, ch, 1'($urandom));
   endtask

   task automatic test_random_traffic();
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_register(pcw_pkg::CSR_WDOG_SECONDS,
                        pcw_pkg::CSR_DATA_W'($urandom_range(0, 6)));
         write_register(pcw_pkg::CSR_REL_SECONDS,
                        {8'($urandom), 8'($urandom_range(0, 5))});
         write_register(pcw_pkg::CSR_TICKS_PER_SEC,
                        {8'($urandom), 8'($urandom_range(0, 4))});
         idle_enable = (p != 1);
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            if (p != 1 && i % 150 == 0) idle_enable = ($urandom_range(0, 3) != 0);
            if (p == 2 && i == 200) wait_for_idle();
            send_random_request();
         end
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      active_cfg.wdog_seconds = pcw_pkg::WDOG_SECONDS_RST;
      active_cfg.rel_seconds = pcw_pkg::REL_SECONDS_RST;
      active_cfg.ticks_per_sec = pcw_pkg::TICKS_PER_SEC_RST;
      switch_state = '0;
      switch_state.chan_bits = '1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_commands();
      test_config_extremes();
      test_random_traffic();
      wait_for_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
